### sv/idiv_pkg.sv
package idiv_pkg;

    // Width of the operand and result ports.
    localparam int FIELD_WIDTH = 64;
    // Default operand width used by the arithmetic.
    localparam int DEF_DATA_WIDTH = 64;

    // Operation select codes.
    localparam logic [1:0] FUNC_UQUO = 2'd0;
    localparam logic [1:0] FUNC_UREM = 2'd1;
    localparam logic [1:0] FUNC_SQUO = 2'd2;
    localparam logic [1:0] FUNC_SREM = 2'd3;

    // Per-word control that rides along the divide pipeline.
    typedef struct packed {
        logic want_rem;   // deliver remainder instead of quotient
        logic neg_q;      // negate quotient at the end
        logic neg_r;      // negate remainder at the end
        logic div_zero;   // divisor was zero, answer forced to 0
    } t_ctrl;

endpackage

### sv/idiv_pre.sv
module idiv_pre #(
    parameter int DATA_WIDTH = idiv_pkg::DEF_DATA_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [1:0]                        i_func,
    input  logic [idiv_pkg::FIELD_WIDTH-1:0]  i_dividend,
    input  logic [idiv_pkg::FIELD_WIDTH-1:0]  i_divisor,
    output logic                              o_valid,
    output logic [DATA_WIDTH-1:0]             o_num,
    output logic [DATA_WIDTH-1:0]             o_den,
    output idiv_pkg::t_ctrl                   o_ctrl
);
    import idiv_pkg::*;

    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
    logic                  is_signed;
    logic                  a_neg;
    logic                  b_neg;
    logic [DATA_WIDTH-1:0] n_num;
    logic [DATA_WIDTH-1:0] n_den;
    t_ctrl                 n_ctrl;

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_num;
    logic [DATA_WIDTH-1:0] r_den;
    t_ctrl                 r_ctrl;

    // Only the low DATA_WIDTH bits take part.
    assign a = i_dividend[DATA_WIDTH-1:0];
    assign b = i_divisor[DATA_WIDTH-1:0];

    always_comb begin
        is_signed = (i_func == FUNC_SQUO) || (i_func == FUNC_SREM);
        a_neg     = is_signed & a[DATA_WIDTH-1];
        b_neg     = is_signed & b[DATA_WIDTH-1];
        n_num     = a_neg ? (~a + 1'b1) : a;
        n_den     = b_neg ? (~b + 1'b1) : b;
        n_ctrl.want_rem = (i_func == FUNC_UREM) || (i_func == FUNC_SREM);
        n_ctrl.neg_q    = a_neg ^ b_neg;
        n_ctrl.neg_r    = a_neg;
        n_ctrl.div_zero = (b == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num  <= n_num;
        r_den  <= n_den;
        r_ctrl <= n_ctrl;
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_ctrl  = r_ctrl;

endmodule

### sv/idiv_step.sv
module idiv_step #(
    parameter int DATA_WIDTH = idiv_pkg::DEF_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [DATA_WIDTH-1:0] i_rem,
    input  logic [DATA_WIDTH-1:0] i_nq,
    input  logic [DATA_WIDTH-1:0] i_den,
    input  idiv_pkg::t_ctrl       i_ctrl,
    output logic                  o_valid,
    output logic [DATA_WIDTH-1:0] o_rem,
    output logic [DATA_WIDTH-1:0] o_nq,
    output logic [DATA_WIDTH-1:0] o_den,
    output idiv_pkg::t_ctrl       o_ctrl
);
    import idiv_pkg::*;

    // nq: unused dividend bits at the top, quotient bits shifting in at the bottom.
    logic [DATA_WIDTH-1:0] rem_sh;
    logic [DATA_WIDTH:0]   diff;
    logic                  take;
    logic [DATA_WIDTH-1:0] n_rem;
    logic [DATA_WIDTH-1:0] n_nq;

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_nq;
    logic [DATA_WIDTH-1:0] r_den;
    t_ctrl                 r_ctrl;

    always_comb begin
        rem_sh = {i_rem[DATA_WIDTH-2:0], i_nq[DATA_WIDTH-1]};
        // carry-out of the shift is kept as bit DATA_WIDTH
        diff   = {i_rem[DATA_WIDTH-1], rem_sh} - {1'b0, i_den};
        take   = ~diff[DATA_WIDTH];
        n_rem  = take ? diff[DATA_WIDTH-1:0] : rem_sh;
        n_nq   = {i_nq[DATA_WIDTH-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_nq   <= n_nq;
        r_den  <= i_den;
        r_ctrl <= i_ctrl;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_nq    = r_nq;
    assign o_den   = r_den;
    assign o_ctrl  = r_ctrl;

endmodule

### sv/idiv_post.sv
module idiv_post #(
    parameter int DATA_WIDTH = idiv_pkg::DEF_DATA_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [DATA_WIDTH-1:0]             i_rem,
    input  logic [DATA_WIDTH-1:0]             i_quo,
    input  idiv_pkg::t_ctrl                   i_ctrl,
    output logic                              o_valid,
    output logic [idiv_pkg::FIELD_WIDTH-1:0]  o_answer
);
    import idiv_pkg::*;

    logic [DATA_WIDTH-1:0]  pick;
    logic                   neg;
    logic [DATA_WIDTH-1:0]  n_res;

    logic                   r_valid;
    logic [FIELD_WIDTH-1:0] r_answer;

    always_comb begin
        pick  = i_ctrl.want_rem ? i_rem : i_quo;
        neg   = i_ctrl.want_rem ? i_ctrl.neg_r : i_ctrl.neg_q;
        n_res = neg ? (~pick + 1'b1) : pick;
        if (i_ctrl.div_zero) begin
            n_res = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_answer <= FIELD_WIDTH'(n_res);
    end

    assign o_valid  = r_valid;
    assign o_answer = r_answer;

endmodule

### sv/integer_divider_64_core.sv
// Path from start to o_valid: the idiv_pre register, the idiv_step chain, then the idiv_post output register.
// Throughput: one word per cycle; one restoring step per pipeline stage.
// busy is tied low: the pipeline never stalls and results cannot be held off.
// Reset (i_rst_n low, synchronous) clears every stage valid bit; words in flight
// are dropped and no strobe is issued for them.
module integer_divider_64_core #(
    parameter int DATA_WIDTH = idiv_pkg::DEF_DATA_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_func,
    input  logic [idiv_pkg::FIELD_WIDTH-1:0]  i_dividend,
    input  logic [idiv_pkg::FIELD_WIDTH-1:0]  i_divisor,
    output logic                              o_valid,
    output logic [idiv_pkg::FIELD_WIDTH-1:0]  o_answer
);
    import idiv_pkg::*;

    localparam int LATENCY = DATA_WIDTH + 2;

    // Stage k of the chain holds the word after k restoring steps.
    logic                  s_valid [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] s_rem   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] s_nq    [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] s_den   [0:DATA_WIDTH];
    t_ctrl                 s_ctrl  [0:DATA_WIDTH];

    logic accept;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Operand conditioning: magnitudes, sign flags, zero-divisor flag.
    idiv_pre #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_pre (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (accept),
        .i_func     (i_func),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .o_valid    (s_valid[0]),
        .o_num      (s_nq[0]),
        .o_den      (s_den[0]),
        .o_ctrl     (s_ctrl[0])
    );

    // Partial remainder starts at zero.
    assign s_rem[0] = '0;

    // One quotient bit per stage, MSB first.
    for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
        idiv_step #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[k]),
            .i_rem   (s_rem[k]),
            .i_nq    (s_nq[k]),
            .i_den   (s_den[k]),
            .i_ctrl  (s_ctrl[k]),
            .o_valid (s_valid[k+1]),
            .o_rem   (s_rem[k+1]),
            .o_nq    (s_nq[k+1]),
            .o_den   (s_den[k+1]),
            .o_ctrl  (s_ctrl[k+1])
        );
    end

    // Sign fix-up, result select and output register.
    idiv_post #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_valid[DATA_WIDTH]),
        .i_rem    (s_rem[DATA_WIDTH]),
        .i_quo    (s_nq[DATA_WIDTH]),
        .i_ctrl   (s_ctrl[DATA_WIDTH]),
        .o_valid  (o_valid),
        .o_answer (o_answer)
    );

    // Every accepted word must come out as an o_valid strobe after passing through the pipeline.
    a_accept_to_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_valid)
        else $error("accepted word did not come out on time");

    a_strobe_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, LATENCY))
        else $error("strobe without a matching accepted word");

    a_zero_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_divisor[DATA_WIDTH-1:0] == '0, LATENCY) |-> o_answer == '0)
        else $error("zero divisor gave nonzero answer");

    a_div_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_func == FUNC_UQUO && i_divisor[DATA_WIDTH-1:0] == 1, LATENCY)
        |-> o_answer == FIELD_WIDTH'($past(i_dividend[DATA_WIDTH-1:0], LATENCY)))
        else $error("unsigned divide by one changed the dividend");

endmodule
